[rtl/pbve_pkg.sv]
// Package for the packed bit vector editor.
// Holds the command and response types, operation and status codes, and sizing defaults.
// No dependencies.
package pbve_pkg;

    // Default storage size in bits.
    localparam int CAPACITY_DEF = 256;

    // Field widths of the command and response items.
    localparam int OP_W    = 3;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int LEN_W   = 9;
    localparam int STAT_W  = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // One command item.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
        logic               bit_value;
        logic [COUNT_W-1:0] count;
    } pbve_cmd_t;

    // One response item.
    typedef struct packed {
        logic              read_bit;
        logic [LEN_W-1:0]  length;
        logic [STAT_W-1:0] status;
    } pbve_rsp_t;

endpackage

[rtl/pbve_edit.sv]
// Combinational edit unit of the packed bit vector editor.
// Computes the next vector, next length and the response for one command.
// Depends on pbve_pkg.
module pbve_edit
    import pbve_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LW       = $clog2(CAPACITY + 1)
)
(
    input  logic [CAPACITY-1:0] vec,
    input  logic [LW-1:0]       len,
    input  pbve_cmd_t           cmd,
    output logic [CAPACITY-1:0] vec_next,
    output logic [LW-1:0]       len_next,
    output pbve_rsp_t           rsp
);

    // Compare width wide enough for index plus count and for the length.
    localparam int SW = ((LW > COUNT_W) ? LW : COUNT_W) + 1;

    logic [SW-1:0]       idx_w;
    logic [SW-1:0]       cnt_w;
    logic [SW-1:0]       len_w;
    logic                in_range;
    logic                full;
    logic [CAPACITY-1:0] one_hot_idx;
    logic [CAPACITY-1:0] one_hot_len;
    logic [CAPACITY-1:0] low_mask;
    logic [CAPACITY-1:0] rd_shift;
    logic [CAPACITY-1:0] app_vec;
    logic [CAPACITY-1:0] wr_vec;
    logic [CAPACITY-1:0] ins_vec;
    logic [CAPACITY-1:0] ers_vec;
    logic [STAT_W-1:0]   status;
    logic                read_bit;

    // Shared position decode and range checks.
    always_comb
    begin
        idx_w       = SW'(cmd.index);
        cnt_w       = SW'(cmd.count);
        len_w       = SW'(len);
        in_range    = (idx_w < len_w);
        full        = (len_w == SW'(CAPACITY));
        one_hot_idx = {{(CAPACITY-1){1'b0}}, 1'b1} << cmd.index;
        one_hot_len = {{(CAPACITY-1){1'b0}}, 1'b1} << len;
        low_mask    = one_hot_idx - {{(CAPACITY-1){1'b0}}, 1'b1};
        rd_shift    = vec >> cmd.index;
    end

    // Candidate vectors for each kind of edit; bits above the length stay zero.
    always_comb
    begin
        app_vec = vec | (cmd.bit_value ? one_hot_len : '0);
        wr_vec  = (vec & ~one_hot_idx) | (cmd.bit_value ? one_hot_idx : '0);
        ins_vec = (vec & low_mask) | ((vec << 1) & ~low_mask & ~one_hot_idx)
                | (cmd.bit_value ? one_hot_idx : '0);
        ers_vec = (vec & low_mask) | ((vec >> cmd.count) & ~low_mask);
    end

    // Operation select.
    always_comb
    begin
        vec_next = vec;
        len_next = len;
        status   = ST_OK;
        read_bit = 1'b0;
        case (cmd.op)
            OP_READ:
            begin
                if (in_range)
                    read_bit = rd_shift[0];
                else
                    status = ST_RANGE;
            end
            OP_WRITE, OP_APPEND, OP_INSERT:
            begin
                if (in_range && cmd.op != OP_APPEND) begin
                    if (cmd.op == OP_WRITE) begin
                        vec_next = wr_vec;
                    end else if (full) begin
                        status = ST_FULL;
                    end else begin
                        vec_next = ins_vec;
                        len_next = len + LW'(1);
                    end
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    vec_next = app_vec;
                    len_next = len + LW'(1);
                end
            end
            OP_ERASE:
            begin
                if ((idx_w + cnt_w) > len_w) begin
                    status = ST_RANGE;
                end else begin
                    vec_next = ers_vec;
                    len_next = LW'(len_w - cnt_w);
                end
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    // Response item.
    assign rsp.read_bit = read_bit;
    assign rsp.length   = LEN_W'(len_next);
    assign rsp.status   = status;

endmodule

[rtl/packed_bit_vector_editor_core.sv]
// Top level of the packed bit vector editor.
// Each accepted command is registered in cmd_reg and cmd_valid_reg; the edit result is then registered
// into the vector state and response registers, and done rises with the response.
// Throughput: one command per cycle; busy stays low, and each edit is one pass of pbve_edit.
// Reset clears the vector to all zeros and the length to zero at once; no clearing pass.
// Responses are shown for one cycle on rsp with done high; the receiver cannot stall.
// Depends on pbve_pkg and pbve_edit.
module packed_bit_vector_editor_core
    import pbve_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pbve_cmd_t cmd,
    output logic      done,
    output pbve_rsp_t rsp
);

    localparam int LW = $clog2(CAPACITY + 1);

    pbve_cmd_t           cmd_reg;
    logic                cmd_valid_reg;
    logic [CAPACITY-1:0] vec_reg;
    logic [CAPACITY-1:0] vec_next;
    logic [LW-1:0]       len_reg;
    logic [LW-1:0]       len_next;
    pbve_rsp_t           rsp_reg;
    pbve_rsp_t           rsp_next;
    logic                done_reg;

    // The block never holds off a command.
    assign busy = 1'b0;

    // Command register; the payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= start && !busy;
    end

    // Edit logic between the command register and the state and response registers.
    pbve_edit #(
        .CAPACITY (CAPACITY),
        .LW       (LW)
    ) u_edit (
        .vec      (vec_reg),
        .len      (len_reg),
        .cmd      (cmd_reg),
        .vec_next (vec_next),
        .len_next (len_next),
        .rsp      (rsp_next)
    );

    // Vector state and response strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vec_reg  <= '0;
            len_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= cmd_valid_reg;
            if (cmd_valid_reg) begin
                vec_reg <= vec_next;
                len_reg <= len_next;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The length never exceeds the capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(len_reg) <= LW'(CAPACITY))
        else $error("length above capacity");

    // Storage above the length is always zero.
    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_reg >> len_reg) == '0)
        else $error("nonzero bits above length");

    // Every registered command gives exactly one response on the next cycle.
    a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |=> done_reg)
        else $error("response missing");

    // A full status only comes back when the vector is at capacity.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == ST_FULL) |-> (len_reg == LW'(CAPACITY)))
        else $error("full status below capacity");

    // A read bit is only reported with an ok status.
    a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.read_bit) |-> (rsp_reg.status == ST_OK))
        else $error("read bit with error status");

endmodule
